// File: rtl/core/mkqi_pkg.sv
// mkqi_pkg: shared types, constants and tables for the morton key core
// depends on nothing; imported by every module in rtl/core
package mkqi_pkg;

  // sizes
  localparam int COORD_BITS  = 32;
  localparam int MAX_DIMS    = 3;
  localparam int MAX_DIGITS  = 9;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int REM_W       = DIFF_W + 1;
  localparam int DEPTH_W     = 4;
  localparam int DIMS_W      = 2;
  localparam int KEY_W       = 31;
  localparam int DIGIT_POS_W = 6;
  localparam int NUM_POS     = MAX_DIGITS + 1;
  localparam int LANE_STAGES = DIFF_W + MAX_DIGITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z     = 3'd7;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_DIGITS = 2'd2
  } err_t;

  // decimal digit weights
  localparam logic [KEY_W-1:0] POW10 [NUM_POS] = '{
    31'd1, 31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000,
    31'd1000000, 31'd10000000, 31'd100000000, 31'd1000000000
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       error_code;
  } out_item_t;

  // control travelling alongside the divider lanes
  typedef struct packed {
    logic               valid;
    err_t               err;
    logic [DIMS_W-1:0]  dims;
    logic [DEPTH_W-1:0] depth;
  } ctrl_t;

endpackage

// File: rtl/core/mkqi_divlane.sv
// mkqi_divlane: one dimension's bit-per-stage floored divider pipeline
// depends on mkqi_pkg; gives the low depth bits of floor(num*2^depth/den)
module mkqi_divlane import mkqi_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIFF_W-1:0]     num_mag,
  input  logic [DIFF_W-1:0]     den_mag,
  input  logic [DEPTH_W-1:0]    depth,
  input  logic                  neg,
  output logic [MAX_DIGITS-1:0] idx_bits
);

  logic [REM_W-1:0]      rem_r    [LANE_STAGES];
  logic [REM_W-1:0]      rem_nxt  [LANE_STAGES];
  logic [DIFF_W-1:0]     num_r    [LANE_STAGES];
  logic [DIFF_W-1:0]     num_nxt  [LANE_STAGES];
  logic [DIFF_W-1:0]     den_r    [LANE_STAGES];
  logic [MAX_DIGITS-1:0] frac_r   [LANE_STAGES];
  logic [MAX_DIGITS-1:0] frac_nxt [LANE_STAGES];
  logic [DEPTH_W-1:0]    dep_r    [LANE_STAGES];
  logic                  neg_r    [LANE_STAGES];

  logic [REM_W-1:0]      rem_p    [LANE_STAGES];
  logic [DIFF_W-1:0]     num_p    [LANE_STAGES];
  logic [DIFF_W-1:0]     den_p    [LANE_STAGES];
  logic [MAX_DIGITS-1:0] frac_p   [LANE_STAGES];
  logic [DEPTH_W-1:0]    dep_p    [LANE_STAGES];
  logic                  neg_p    [LANE_STAGES];

  localparam int LAST = LANE_STAGES - 1;

  for (genvar s = 0; s < LANE_STAGES; s++) begin : g_stage
    // stage inputs
    if (s == 0) begin : g_first
      assign rem_p[s]  = '0;
      assign num_p[s]  = num_mag;
      assign den_p[s]  = den_mag;
      assign frac_p[s] = '0;
      assign dep_p[s]  = depth;
      assign neg_p[s]  = neg;
    end else begin : g_next
      assign rem_p[s]  = rem_r[s-1];
      assign num_p[s]  = num_r[s-1];
      assign den_p[s]  = den_r[s-1];
      assign frac_p[s] = frac_r[s-1];
      assign dep_p[s]  = dep_r[s-1];
      assign neg_p[s]  = neg_r[s-1];
    end

    if (s < DIFF_W) begin : g_mod
      // remainder step: bring in one dividend bit, subtract if it fits
      logic [REM_W-1:0] trial;
      always_comb begin
        trial       = {rem_p[s][REM_W-2:0], num_p[s][DIFF_W-1]};
        num_nxt[s]  = num_p[s] << 1;
        frac_nxt[s] = frac_p[s];
        if (trial >= {1'b0, den_p[s]}) begin
          rem_nxt[s] = trial - {1'b0, den_p[s]};
        end else begin
          rem_nxt[s] = trial;
        end
      end
    end else begin : g_frac
      // fraction step, only while below the configured depth
      logic [REM_W-1:0] trial;
      logic             fits;
      always_comb begin
        trial      = {rem_p[s][REM_W-2:0], 1'b0};
        fits       = trial >= {1'b0, den_p[s]};
        num_nxt[s] = num_p[s];
        if (DEPTH_W'(s - DIFF_W) < dep_p[s]) begin
          rem_nxt[s]  = fits ? (trial - {1'b0, den_p[s]}) : trial;
          frac_nxt[s] = {frac_p[s][MAX_DIGITS-2:0], fits};
        end else begin
          rem_nxt[s]  = rem_p[s];
          frac_nxt[s] = frac_p[s];
        end
      end
    end

    // stage registers
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        num_r[s]  <= num_nxt[s];
        den_r[s]  <= den_p[s];
        frac_r[s] <= frac_nxt[s];
        dep_r[s]  <= dep_p[s];
        neg_r[s]  <= neg_p[s];
      end
    end
  end

  // floored sign fix-up on the low bits
  always_comb begin
    if (!neg_r[LAST]) begin
      idx_bits = frac_r[LAST];
    end else if (rem_r[LAST] != '0) begin
      idx_bits = ~frac_r[LAST];
    end else begin
      idx_bits = MAX_DIGITS'(~frac_r[LAST] + 1'b1);
    end
  end

endmodule

// File: rtl/core/mkqi_keyform.sv
// mkqi_keyform: interleaves cell index bits into the decimal-digit key
// depends on mkqi_pkg; three register stages ending in the output register
module mkqi_keyform import mkqi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ctrl_t                 ctl,
  input  logic [MAX_DIGITS-1:0] idx_x,
  input  logic [MAX_DIGITS-1:0] idx_y,
  input  logic [MAX_DIGITS-1:0] idx_z,
  output logic                  out_valid,
  output out_item_t             out_data
);

  logic [MAX_DIGITS-1:0]  idx [MAX_DIMS];
  logic [NUM_POS-1:0]     mask_nxt;
  logic [DIGIT_POS_W-1:0] lead;
  logic [DIGIT_POS_W-1:0] pos;

  logic                   v1_r, v2_r, v3_r;
  err_t                   err1_r, err2_r, err3_r;
  logic [NUM_POS-1:0]     mask_r;
  logic [KEY_W-1:0]       lo_nxt, hi_nxt;
  logic [KEY_W-1:0]       lo_r, hi_r, key_r;

  assign idx[0] = idx_x;
  assign idx[1] = idx_y;
  assign idx[2] = idx_z;

  // digit mask: a leading one at depth*dims; bit k of dimension d lands at k*dims + dims-1-d
  always_comb begin
    mask_nxt = '0;
    lead     = DIGIT_POS_W'(ctl.depth) * DIGIT_POS_W'(ctl.dims);
    pos      = '0;
    if (ctl.err == ERR_NONE) begin
      for (int q = 0; q < NUM_POS; q++) begin
        if (lead == DIGIT_POS_W'(q)) begin
          mask_nxt[q] = 1'b1;
        end
      end
      for (int k = 0; k < MAX_DIGITS; k++) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          pos = DIGIT_POS_W'(k) * DIGIT_POS_W'(ctl.dims) + DIGIT_POS_W'(ctl.dims)
                - DIGIT_POS_W'(d + 1);
          if ((DIMS_W'(d) < ctl.dims) && (DEPTH_W'(k) < ctl.depth)) begin
            for (int q = 0; q < NUM_POS; q++) begin
              if (pos == DIGIT_POS_W'(q)) begin
                mask_nxt[q] = mask_nxt[q] | idx[d][k];
              end
            end
          end
        end
      end
    end
  end

  // partial sums of digit weights
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int q = 0; q < NUM_POS / 2; q++) begin
      lo_nxt = lo_nxt + (mask_r[q] ? POW10[q] : '0);
    end
    for (int q = NUM_POS / 2; q < NUM_POS; q++) begin
      hi_nxt = hi_nxt + (mask_r[q] ? POW10[q] : '0);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= ctl.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      mask_r <= mask_nxt;
      err1_r <= ctl.err;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      err2_r <= err1_r;
      key_r  <= lo_r + hi_r;
      err3_r <= err2_r;
    end
  end

  assign out_valid           = v3_r;
  assign out_data.key        = key_r;
  assign out_data.error_code = err3_r;

endmodule

// File: rtl/core/morton_key_quantize_interleave_core.sv
// morton_key_quantize_interleave_core: top level of the morton key block
// depends on mkqi_pkg, mkqi_divlane and mkqi_keyform
//
// Usage
//   in_valid/in_stall/in_data carry one point per transaction; out_valid/
//   out_stall/out_data carry one key and error code per point, in order.
//   cfg_we/cfg_index/cfg_wdata write the eight range and format registers;
//   write them only while no transaction is in flight.
//   Throughput: one transaction per cycle while the pipeline is not
//   held. Each dimension has its own divider lane of 42 stages, one
//   quotient or remainder bit per stage, which sets the depth of the
//   pipeline.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: three dimensions, depth three, ranges [0,1].
//   While out_valid is high and out_stall is high, the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
module morton_key_quantize_interleave_core import mkqi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DIMS_W-1:0]            dims_r;
  logic [DEPTH_W-1:0]           depth_r;
  logic signed [COORD_BITS-1:0] min_r [MAX_DIMS];
  logic signed [COORD_BITS-1:0] max_r [MAX_DIMS];

  logic                         en;
  logic [DIMS_W-1:0]            dims_eff;
  logic [DIGIT_POS_W-1:0]       digits;
  logic                         range_zero;
  err_t                         err_nxt;
  logic signed [COORD_BITS-1:0] coord [MAX_DIMS];

  ctrl_t                        ctl0_r, ctl1_r;
  ctrl_t                        ctl_r [LANE_STAGES];
  logic [DIFF_W-1:0]            dif_r [MAX_DIMS];
  logic [DIFF_W-1:0]            rng_r [MAX_DIMS];
  logic [DIFF_W-1:0]            mag_r [MAX_DIMS];
  logic [DIFF_W-1:0]            den_r [MAX_DIMS];
  logic                         neg_r [MAX_DIMS];
  logic [MAX_DIGITS-1:0]        idx   [MAX_DIMS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= DIMS_W'(MAX_DIMS);
      depth_r <= DEPTH_W'(3);
      for (int d = 0; d < MAX_DIMS; d++) begin
        min_r[d] <= '0;
        max_r[d] <= COORD_BITS'(1);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMS_USED: dims_r   <= cfg_wdata[DIMS_W-1:0];
        REG_DEPTH:     depth_r  <= cfg_wdata[DEPTH_W-1:0];
        REG_MIN_X:     min_r[0] <= cfg_wdata[COORD_BITS-1:0];
        REG_MAX_X:     max_r[0] <= cfg_wdata[COORD_BITS-1:0];
        REG_MIN_Y:     min_r[1] <= cfg_wdata[COORD_BITS-1:0];
        REG_MAX_Y:     max_r[1] <= cfg_wdata[COORD_BITS-1:0];
        REG_MIN_Z:     min_r[2] <= cfg_wdata[COORD_BITS-1:0];
        REG_MAX_Z:     max_r[2] <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything while a finished key is refused
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign coord[0] = in_data.coord_x;
  assign coord[1] = in_data.coord_y;
  assign coord[2] = in_data.coord_z;

  // error checks from configuration
  always_comb begin
    dims_eff   = (dims_r == '0) ? DIMS_W'(1) : dims_r;
    digits     = DIGIT_POS_W'(depth_r) * DIGIT_POS_W'(dims_eff);
    range_zero = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((DIMS_W'(d) < dims_eff) && (max_r[d] == min_r[d])) begin
        range_zero = 1'b1;
      end
    end
    if (range_zero) begin
      err_nxt = ERR_RANGE;
    end else if (digits > DIGIT_POS_W'(MAX_DIGITS)) begin
      err_nxt = ERR_DIGITS;
    end else begin
      err_nxt = ERR_NONE;
    end
  end

  // stage 0: offsets and ranges
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
    end else if (en) begin
      ctl0_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl0_r.err   <= err_nxt;
      ctl0_r.dims  <= dims_eff;
      ctl0_r.depth <= depth_r;
      for (int d = 0; d < MAX_DIMS; d++) begin
        dif_r[d] <= {coord[d][COORD_BITS-1], coord[d]} - {min_r[d][COORD_BITS-1], min_r[d]};
        rng_r[d] <= {max_r[d][COORD_BITS-1], max_r[d]} - {min_r[d][COORD_BITS-1], min_r[d]};
      end
    end
  end

  // stage 1: magnitudes and quotient sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
    end else if (en) begin
      ctl1_r.valid <= ctl0_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.err   <= ctl0_r.err;
      ctl1_r.dims  <= ctl0_r.dims;
      ctl1_r.depth <= ctl0_r.depth;
      for (int d = 0; d < MAX_DIMS; d++) begin
        mag_r[d] <= dif_r[d][DIFF_W-1] ? DIFF_W'(-dif_r[d]) : dif_r[d];
        den_r[d] <= rng_r[d][DIFF_W-1] ? DIFF_W'(-rng_r[d]) : rng_r[d];
        neg_r[d] <= dif_r[d][DIFF_W-1] ^ rng_r[d][DIFF_W-1];
      end
    end
  end

  // control line alongside the divider lanes
  for (genvar s = 0; s < LANE_STAGES; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].valid <= 1'b0;
      end else if (en) begin
        ctl_r[s].valid <= (s == 0) ? ctl1_r.valid : ctl_r[(s == 0) ? 0 : s-1].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 0) begin
          ctl_r[s].err   <= ctl1_r.err;
          ctl_r[s].dims  <= ctl1_r.dims;
          ctl_r[s].depth <= ctl1_r.depth;
        end else begin
          ctl_r[s].err   <= ctl_r[(s == 0) ? 0 : s-1].err;
          ctl_r[s].dims  <= ctl_r[(s == 0) ? 0 : s-1].dims;
          ctl_r[s].depth <= ctl_r[(s == 0) ? 0 : s-1].depth;
        end
      end
    end
  end

  // one divider lane per dimension
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    mkqi_divlane u_lane (
      .clk      (clk),
      .en       (en),
      .num_mag  (mag_r[d]),
      .den_mag  (den_r[d]),
      .depth    (ctl1_r.depth),
      .neg      (neg_r[d]),
      .idx_bits (idx[d])
    );
  end

  // key assembly and output register
  mkqi_keyform u_keyform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl_r[LANE_STAGES-1]),
    .idx_x     (idx[0]),
    .idx_y     (idx[1]),
    .idx_z     (idx[2]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an error transaction carries a zero key
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code != ERR_NONE)) |-> (out_data.key == '0))
    else $error("error transaction with nonzero key");

  // a good key always has its leading one
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code == ERR_NONE)) |-> (out_data.key != '0))
    else $error("good transaction with zero key");

  // reset empties the output
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule
